/* sv/s2c_pkg.sv */
// s2c_pkg: shared types, constants and helper functions for seconds_to_calendar
// no dependencies; used by the interfaces, controller, datapath and top level

package s2c_pkg;

   localparam int SECS_W    = 32;
   localparam int YEAR_W    = 12;
   localparam int MONTH_W   = 4;
   localparam int DAY_W     = 5;
   localparam int WEEKDAY_W = 3;
   localparam int HOUR_W    = 5;
   localparam int MINUTE_W  = 6;
   localparam int SECOND_W  = 6;

   localparam int DAYS_W    = 16;   // whole days since base, below 49711
   localparam int REM_W     = 17;   // remainder within a day, below 86400
   localparam int DIVD_W    = REM_W + 1;
   localparam int YOFF_W    = 8;    // years since base, 0..136
   localparam int CNT_W     = 1;

   // each pass takes its quotient step before its remainder step
   localparam logic [CNT_W-1:0] DIV_STEPS = 1'd1;

   localparam logic [YEAR_W-1:0]  BASE_YEAR    = 12'd2000;
   localparam logic [DAYS_W-1:0]  BASE_WEEKDAY = 16'd6;
   localparam logic [YOFF_W-1:0]  LEAP_SKIP    = 8'd100;   // 2100 is a common year
   localparam logic [MONTH_W-1:0] FIRST_MONTH  = 4'd1;
   localparam logic [MONTH_W-1:0] LAST_MONTH   = 4'd12;
   localparam logic [MONTH_W-1:0] FEBRUARY     = 4'd2;

   localparam logic [DIVD_W-1:0] SECS_PER_DAY  = 18'd86400;
   localparam logic [DIVD_W-1:0] SECS_PER_HOUR = 18'd3600;
   localparam logic [DIVD_W-1:0] SECS_PER_MIN  = 18'd60;
   localparam logic [DIVD_W-1:0] DAYS_PER_WEEK = 18'd7;

   // rounded-up reciprocals, exact over each pass's numerator range
   localparam logic [25:0] RECIP_DAY  = 26'd50903317;   // 2^35 / 675, on seconds / 128
   localparam logic [17:0] RECIP_HOUR = 18'd149131;     // 2^29 / 3600
   localparam logic [12:0] RECIP_MIN  = 13'd4370;       // 2^18 / 60
   localparam logic [16:0] RECIP_WEEK = 17'd74899;      // 2^19 / 7

   // divider pass select
   typedef logic [1:0] div_sel_type;
   localparam div_sel_type DIV_DAY  = 2'd0;
   localparam div_sel_type DIV_HOUR = 2'd1;
   localparam div_sel_type DIV_MIN  = 2'd2;
   localparam div_sel_type DIV_WEEK = 2'd3;

   localparam logic [4:0] MONTH_LEN [12] = '{
      5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
      5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
   };

   typedef struct packed {
      logic        start;
      logic        div_step;
      logic        div_done;
      div_sel_type div_sel;
      logic        year_step;
      logic        month_step;
      logic        emit;
   } cmd_type;

   typedef struct packed {
      logic year_fits;
      logic month_fits;
   } status_type;

   typedef struct packed {
      logic [YEAR_W-1:0]    year;
      logic [MONTH_W-1:0]   month;
      logic [DAY_W-1:0]     day;
      logic [WEEKDAY_W-1:0] weekday;
      logic [HOUR_W-1:0]    hour;
      logic [MINUTE_W-1:0]  minute;
      logic [SECOND_W-1:0]  second;
   } rsp_payload_type;

   function automatic logic [DIVD_W-1:0] div_divisor(div_sel_type sel);
      logic [DIVD_W-1:0] d;
      unique case (sel)
         DIV_DAY:  d = SECS_PER_DAY;
         DIV_HOUR: d = SECS_PER_HOUR;
         DIV_MIN:  d = SECS_PER_MIN;
         DIV_WEEK: d = DAYS_PER_WEEK;
         default:  d = SECS_PER_DAY;
      endcase
      return d;
   endfunction

   // years counted from 2000; only 2100 breaks the four-year rule in range
   function automatic logic is_leap(logic [YOFF_W-1:0] yoff);
      return (yoff[1:0] == 2'b00) && (yoff != LEAP_SKIP);
   endfunction

   function automatic logic [4:0] month_days(logic [MONTH_W-1:0] month, logic leap);
      logic [4:0] len;
      if (month == FEBRUARY && leap) begin
         len = 5'd29;
      end else begin
         len = MONTH_LEN[4'(month - FIRST_MONTH)];
      end
      return len;
   endfunction

endpackage

/* sv/s2c_ifs.sv */
// s2c_req_if / s2c_rsp_if: valid-ready channels for requests and results
// depends on s2c_pkg for field widths

interface s2c_req_if;
   logic                         valid;
   logic                         ready;
   logic [s2c_pkg::SECS_W-1:0]   epoch_seconds;

   modport source (output valid, output epoch_seconds, input ready);
   modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface s2c_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [s2c_pkg::YEAR_W-1:0]      year;
   logic [s2c_pkg::MONTH_W-1:0]     month;
   logic [s2c_pkg::DAY_W-1:0]       day;
   logic [s2c_pkg::WEEKDAY_W-1:0]   weekday;
   logic [s2c_pkg::HOUR_W-1:0]      hour;
   logic [s2c_pkg::MINUTE_W-1:0]    minute;
   logic [s2c_pkg::SECOND_W-1:0]    second;

   modport source (output valid, output year, output month, output day, output weekday,
                   output hour, output minute, output second, input ready);
   modport sink   (input valid, input year, input month, input day, input weekday,
                   input hour, input minute, input second, output ready);
endinterface

/* sv/s2c_ctrl.sv */
// s2c_ctrl: sequencer for the divider passes, year walk, month walk and output load
// depends on s2c_pkg (command and status structs, pass codes)

module s2c_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  s2c_pkg::status_type status,
   output s2c_pkg::cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_DIV   = 3'd1;
   localparam logic [2:0] ST_YEAR  = 3'd2;
   localparam logic [2:0] ST_MONTH = 3'd3;
   localparam logic [2:0] ST_EMIT  = 3'd4;

   logic [2:0]                    state_ff, state_in;
   s2c_pkg::div_sel_type          sel_ff, sel_in;
   logic [s2c_pkg::CNT_W-1:0]     cnt_ff, cnt_in;
   logic                          out_valid_ff, out_valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = out_valid_ff;

   always_comb begin
      state_in       = state_ff;
      sel_in         = sel_ff;
      cnt_in         = cnt_ff;
      cmd            = '0;
      cmd.div_sel    = sel_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               sel_in    = s2c_pkg::DIV_DAY;
               cnt_in    = '0;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (cnt_ff == s2c_pkg::DIV_STEPS) begin
               cmd.div_done = 1'b1;
               cnt_in       = '0;
               if (sel_ff == s2c_pkg::DIV_WEEK) begin
                  state_in = ST_YEAR;
               end else begin
                  sel_in = s2c_pkg::div_sel_type'(sel_ff + 2'd1);
               end
            end else begin
               cmd.div_step = 1'b1;
               cnt_in       = cnt_ff + 1'd1;
            end
         end
         ST_YEAR: begin
            if (status.year_fits) begin
               state_in = ST_MONTH;
            end else begin
               cmd.year_step = 1'b1;
            end
         end
         ST_MONTH: begin
            if (status.month_fits) begin
               state_in = ST_EMIT;
            end else begin
               cmd.month_step = 1'b1;
            end
         end
         ST_EMIT: begin
            if (!out_valid_ff || rsp_ready) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (cmd.emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sel_ff       <= s2c_pkg::DIV_DAY;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

/* sv/s2c_dpath.sv */
// s2c_dpath: reciprocal-multiply divider, day/year/month counters and result register
// depends on s2c_pkg (command and status structs, tables, widths)

module s2c_dpath (
   input  logic                          clock,
   input  logic [s2c_pkg::SECS_W-1:0]    req_secs,
   input  s2c_pkg::cmd_type              cmd,
   output s2c_pkg::status_type           status,
   output s2c_pkg::rsp_payload_type      rsp_payload
);

   logic [s2c_pkg::SECS_W-1:0]     num_ff, num_in;
   logic [s2c_pkg::DAYS_W-1:0]     quo_ff, quo_in;
   logic [s2c_pkg::DAYS_W-1:0]     total_days_ff, total_days_in;
   logic [s2c_pkg::DAYS_W-1:0]     days_ff, days_in;
   logic [s2c_pkg::YOFF_W-1:0]     yoff_ff, yoff_in;
   logic [s2c_pkg::MONTH_W-1:0]    month_ff, month_in;
   logic [s2c_pkg::HOUR_W-1:0]     hour_ff, hour_in;
   logic [s2c_pkg::MINUTE_W-1:0]   minute_ff, minute_in;
   logic [s2c_pkg::SECOND_W-1:0]   second_ff, second_in;
   logic [s2c_pkg::WEEKDAY_W-1:0]  weekday_ff, weekday_in;
   s2c_pkg::rsp_payload_type       out_ff, out_in;

   logic [50:0]                    day_prod;
   logic [34:0]                    hour_prod;
   logic [24:0]                    min_prod;
   logic [32:0]                    week_prod;
   logic [s2c_pkg::DAYS_W-1:0]     div_quo;
   logic [s2c_pkg::DIVD_W-1:0]     div_d;
   logic [s2c_pkg::DIVD_W-1:0]     div_prod;
   logic [s2c_pkg::DIVD_W-1:0]     div_rem;
   logic [s2c_pkg::DAYS_W-1:0]     wk_num;
   logic                           leap;
   logic [8:0]                     year_len;
   logic [4:0]                     month_len;

   // quotient by reciprocal; days divide seconds / 128 by 675 to keep the operand at 25 bits
   assign day_prod  = 51'(num_ff[31:7]) * 51'(s2c_pkg::RECIP_DAY);
   assign hour_prod = 35'(num_ff[16:0]) * 35'(s2c_pkg::RECIP_HOUR);
   assign min_prod  = 25'(num_ff[11:0]) * 25'(s2c_pkg::RECIP_MIN);
   assign week_prod = 33'(num_ff[15:0]) * 33'(s2c_pkg::RECIP_WEEK);

   always_comb begin
      unique case (cmd.div_sel)
         s2c_pkg::DIV_DAY:  div_quo = day_prod[50:35];
         s2c_pkg::DIV_HOUR: div_quo = {11'd0, hour_prod[33:29]};
         s2c_pkg::DIV_MIN:  div_quo = {10'd0, min_prod[23:18]};
         s2c_pkg::DIV_WEEK: div_quo = {3'd0, week_prod[31:19]};
         default:           div_quo = day_prod[50:35];
      endcase
   end

   // remainder is below 2^17, so the low product bits are enough
   assign div_d     = s2c_pkg::div_divisor(cmd.div_sel);
   assign div_prod  = {2'd0, quo_ff} * div_d;
   assign div_rem   = num_ff[s2c_pkg::DIVD_W-1:0] - div_prod;
   // day zero is a saturday
   assign wk_num    = total_days_ff + s2c_pkg::BASE_WEEKDAY;

   assign leap      = s2c_pkg::is_leap(yoff_ff);
   assign year_len  = leap ? 9'd366 : 9'd365;
   assign month_len = s2c_pkg::month_days(month_ff, leap);

   assign status.year_fits  = (days_ff < {7'd0, year_len});
   assign status.month_fits = (month_ff == s2c_pkg::LAST_MONTH) ||
                              (days_ff < {11'd0, month_len});
   assign rsp_payload = out_ff;

   always_comb begin
      num_in        = num_ff;
      quo_in        = quo_ff;
      total_days_in = total_days_ff;
      days_in       = days_ff;
      yoff_in       = yoff_ff;
      month_in      = month_ff;
      hour_in       = hour_ff;
      minute_in     = minute_ff;
      second_in     = second_ff;
      weekday_in    = weekday_ff;
      out_in        = out_ff;

      if (cmd.start) begin
         num_in = req_secs;
      end

      if (cmd.div_step) begin
         quo_in = div_quo;
      end

      // save a pass result; the day, hour and minute passes also load the next numerator
      if (cmd.div_done) begin
         unique case (cmd.div_sel)
            s2c_pkg::DIV_DAY: begin
               total_days_in = quo_ff;
               num_in        = {15'd0, div_rem[s2c_pkg::REM_W-1:0]};
            end
            s2c_pkg::DIV_HOUR: begin
               hour_in = quo_ff[4:0];
               num_in  = {15'd0, div_rem[s2c_pkg::REM_W-1:0]};
            end
            s2c_pkg::DIV_MIN: begin
               minute_in = quo_ff[5:0];
               second_in = div_rem[5:0];
               num_in    = {16'd0, wk_num};
               days_in   = total_days_ff;
               yoff_in   = '0;
               month_in  = s2c_pkg::FIRST_MONTH;
            end
            s2c_pkg::DIV_WEEK: begin
               weekday_in = div_rem[2:0];
            end
            default: begin
               weekday_in = weekday_ff;
            end
         endcase
      end

      if (cmd.year_step) begin
         days_in = days_ff - {7'd0, year_len};
         yoff_in = yoff_ff + 8'd1;
      end

      if (cmd.month_step) begin
         days_in  = days_ff - {11'd0, month_len};
         month_in = month_ff + 4'd1;
      end

      if (cmd.emit) begin
         out_in.year    = s2c_pkg::BASE_YEAR + {4'd0, yoff_ff};
         out_in.month   = month_ff;
         out_in.day     = days_ff[4:0] + 5'd1;
         out_in.weekday = weekday_ff;
         out_in.hour    = hour_ff;
         out_in.minute  = minute_ff;
         out_in.second  = second_ff;
      end
   end

   always_ff @(posedge clock) begin
      num_ff        <= num_in;
      quo_ff        <= quo_in;
      total_days_ff <= total_days_in;
      days_ff       <= days_in;
      yoff_ff       <= yoff_in;
      month_ff      <= month_in;
      hour_ff       <= hour_in;
      minute_ff     <= minute_in;
      second_ff     <= second_in;
      weekday_ff    <= weekday_in;
      out_ff        <= out_in;
   end

endmodule

/* sv/seconds_to_calendar.sv */
// seconds_to_calendar: top level, converts seconds since 2000-01-01 00:00:00 to a date
// depends on s2c_pkg, s2c_req_if, s2c_rsp_if, s2c_ctrl and s2c_dpath
//
// channel   direction  handshake            payload
// req_if    in         valid/ready          epoch_seconds[31:0]
// rsp_if    out        valid/ready          year, month, day, weekday, hour, minute, second
//
// one request at a time: after acceptance the sequencer runs four divider passes, each a
// quotient step then a remainder step, then walks over the elapsed years (up to 136) and
// the elapsed months of the last year, each walk ending on a check, and then loads the
// result register
// the result register frees the request side: a new request is taken while a result waits
// reset is synchronous and clears the sequencer and the result valid flag only
// a stalled result holds the finished next request in its last state until taken

module seconds_to_calendar (
   input  logic      clock,
   input  logic      reset,
   s2c_req_if.sink   req_if,
   s2c_rsp_if.source rsp_if
);

   // command and status between sequencer and datapath
   s2c_pkg::cmd_type          cmd;
   s2c_pkg::status_type       status;
   s2c_pkg::rsp_payload_type  rsp_payload;

   // sequencer: idle, four divider passes, year walk, month walk, output load
   s2c_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: reciprocal multiply and one shared remainder step for the day, hour,
   // minute and weekday passes, then subtract-and-compare walks over years and months
   s2c_dpath u_dpath (
      .clock       (clock),
      .req_secs    (req_if.epoch_seconds),
      .cmd         (cmd),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

   // result register fields onto the response channel
   assign rsp_if.year    = rsp_payload.year;
   assign rsp_if.month   = rsp_payload.month;
   assign rsp_if.day     = rsp_payload.day;
   assign rsp_if.weekday = rsp_payload.weekday;
   assign rsp_if.hour    = rsp_payload.hour;
   assign rsp_if.minute  = rsp_payload.minute;
   assign rsp_if.second  = rsp_payload.second;

endmodule

/* sv/s2c_checker.sv */
// s2c_checker: port-level assertions for seconds_to_calendar, attached by bind
// depends on s2c_pkg for field widths and on the top level's channel ports

module s2c_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [s2c_pkg::YEAR_W-1:0]      year,
   input logic [s2c_pkg::MONTH_W-1:0]     month,
   input logic [s2c_pkg::DAY_W-1:0]       day,
   input logic [s2c_pkg::WEEKDAY_W-1:0]   weekday,
   input logic [s2c_pkg::HOUR_W-1:0]      hour,
   input logic [s2c_pkg::MINUTE_W-1:0]    minute,
   input logic [s2c_pkg::SECOND_W-1:0]    second
);

   // no result is pending right after reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result holds its fields
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(year) && $stable(month) &&
         $stable(day) && $stable(weekday) && $stable(hour) && $stable(minute) &&
         $stable(second))
      else $error("result changed while stalled");

   // the converter is busy after taking a request
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken on consecutive cycles");

   // every presented result has each field within its calendar range
   a_fields_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> year >= 12'd2000 && year <= 12'd2136 && month >= 4'd1 &&
         month <= 4'd12 && day >= 5'd1 && day <= 5'd31 && weekday <= 3'd6 &&
         hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59)
      else $error("result field out of range");

endmodule

bind seconds_to_calendar s2c_checker u_s2c_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_if.valid),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .year      (rsp_if.year),
   .month     (rsp_if.month),
   .day       (rsp_if.day),
   .weekday   (rsp_if.weekday),
   .hour      (rsp_if.hour),
   .minute    (rsp_if.minute),
   .second    (rsp_if.second)
);

/* verif/seconds_to_calendar_tb.sv */
// seconds_to_calendar_tb: self-checking bench for the seconds-to-calendar converter
// depends on s2c_pkg, s2c_req_if, s2c_rsp_if and seconds_to_calendar
// a scoreboard class predicts each date from the accepted request and checks results in order

`timescale 1ns / 1ps

module seconds_to_calendar_tb;

   // calendar constants for the predictor
   localparam int unsigned DAY_SECS   = 86400;
   localparam int unsigned HOUR_SECS  = 3600;
   localparam int unsigned MIN_SECS   = 60;
   localparam int unsigned EPOCH_YEAR = 2000;
   localparam int unsigned EPOCH_WDAY = 6;      // 2000-01-01 fell on a saturday

   // run control
   localparam int LIMIT_CYCLES  = 1000000;
   localparam int HOLD_CYCLES   = 600;        // long result-side hold-off
   localparam int DRAIN_CYCLES  = 200;
   localparam int PHASE_ITEMS   = 160;
   localparam int MAX_REPORTS   = 10;

   // gregorian rule, 2100 is a common year
   function automatic bit leap_year(int unsigned yr);
      return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
   endfunction

   function automatic int unsigned month_length(int unsigned yr, int unsigned mon);
      int unsigned len;
      case (mon) inside
         4, 6, 9, 11: len = 30;
         2:           len = leap_year(yr) ? 29 : 28;
         default:     len = 31;
      endcase
      return len;
   endfunction

   // seconds at 00:00:00 on january 1st of a year, used to aim stimulus at boundaries
   function automatic longint year_start_secs(int unsigned yr);
      longint days;
      days = 0;
      for (int unsigned yy = EPOCH_YEAR; yy < yr; yy++) begin
         days += leap_year(yy) ? 366 : 365;
      end
      return days * DAY_SECS;
   endfunction

   class calendar_scoreboard;
      s2c_pkg::rsp_payload_type pending_dates[$];
      int checked;
      int mismatches;

      // walk whole years then whole months, as the block does
      function s2c_pkg::rsp_payload_type to_calendar(logic [s2c_pkg::SECS_W-1:0] secs);
         s2c_pkg::rsp_payload_type cal;
         int unsigned     total_days;
         int unsigned     days;
         int unsigned     left;
         int unsigned     yr;
         int unsigned     mon;
         int unsigned     ylen;
         total_days = secs / DAY_SECS;
         left       = secs % DAY_SECS;
         days       = total_days;
         yr         = EPOCH_YEAR;
         mon        = 1;
         ylen       = leap_year(yr) ? 366 : 365;
         while (days >= ylen) begin
            days -= ylen;
            yr++;
            ylen = leap_year(yr) ? 366 : 365;
         end
         while (mon < 12 && days >= month_length(yr, mon)) begin
            days -= month_length(yr, mon);
            mon++;
         end
         cal.year    = s2c_pkg::YEAR_W'(yr);
         cal.month   = s2c_pkg::MONTH_W'(mon);
         cal.day     = s2c_pkg::DAY_W'(days + 1);
         cal.weekday = s2c_pkg::WEEKDAY_W'((EPOCH_WDAY + total_days) % 7);
         cal.hour    = s2c_pkg::HOUR_W'(left / HOUR_SECS);
         cal.minute  = s2c_pkg::MINUTE_W'((left % HOUR_SECS) / MIN_SECS);
         cal.second  = s2c_pkg::SECOND_W'(left % MIN_SECS);
         return cal;
      endfunction

      function void note_request(logic [s2c_pkg::SECS_W-1:0] secs);
         pending_dates.push_back(to_calendar(secs));
      endfunction

      function void check_result(s2c_pkg::rsp_payload_type got);
         s2c_pkg::rsp_payload_type want;
         if (pending_dates.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("[%0t] unexpected result %0d-%0d-%0d wd%0d %0d:%0d:%0d", $realtime,
                        got.year, got.month, got.day, got.weekday,
                        got.hour, got.minute, got.second);
            end
            return;
         end
         want = pending_dates.pop_front();
         checked++;
         if (got.year !== want.year || got.month !== want.month || got.day !== want.day ||
             got.weekday !== want.weekday || got.hour !== want.hour ||
             got.minute !== want.minute || got.second !== want.second) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("[%0t] want %0d-%0d-%0d wd%0d %0d:%0d:%0d",
                        $realtime, want.year, want.month, want.day, want.weekday,
                        want.hour, want.minute, want.second,
                        " got %0d-%0d-%0d wd%0d %0d:%0d:%0d",
                        got.year, got.month, got.day, got.weekday,
                        got.hour, got.minute, got.second);
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   s2c_req_if req_ch ();
   s2c_rsp_if rsp_ch ();

   seconds_to_calendar dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   // 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   calendar_scoreboard sb = new();

   int   send_idle_pct  = 0;     // chance per cycle that the request side sits idle
   int   recv_stall_pct = 0;     // chance per cycle that the result side drops ready
   int   requests_sent  = 0;
   logic holding        = 1'b0;  // result side held off for a long stretch
   event hold_kick;

   // offer one request, with random idle cycles ahead of it, and wait for it to be taken
   task automatic send_request(input logic [s2c_pkg::SECS_W-1:0] secs);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.epoch_seconds <= secs;
      // ready is read before this edge's updates land, so it is the sampled value
      do begin
         @(posedge clock);
      end while (!req_ch.ready);
      sb.note_request(secs);
      requests_sent++;
   endtask

   // stop offering and wait for every outstanding date to come back
   task automatic pause_until_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_dates.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // random instants, weighted toward year, month and day boundaries
   function automatic logic [s2c_pkg::SECS_W-1:0] pick_seconds();
      longint      t;
      int unsigned yr;
      case ($urandom_range(9)) inside
         0, 1, 2, 3: t = $urandom();
         // first four years convert fastest
         4: t = $urandom_range(1461 * DAY_SECS - 1, 0);
         // around new year
         5: begin
            yr = $urandom_range(2136, 2001);
            t  = year_start_secs(yr) + longint'($urandom_range(2 * DAY_SECS)) - DAY_SECS;
         end
         // end of february, leap day where there is one
         6: begin
            yr = $urandom_range(2135, 2000);
            t  = year_start_secs(yr) + 58 * longint'(DAY_SECS) +
                 longint'($urandom_range(2 * DAY_SECS));
         end
         // the skipped leap year 2100: end of february and end of year
         7: begin
            t = year_start_secs(2100) + ($urandom_range(1) ? 58 : 364) * longint'(DAY_SECS) +
                longint'($urandom_range(2 * DAY_SECS));
         end
         // top of the input range
         8: t = 64'hFFFF_FFFF - longint'($urandom_range(40 * DAY_SECS));
         // time-of-day edges on a random day
         default: begin
            t = longint'($urandom_range(49709)) * DAY_SECS;
            case ($urandom_range(5))
               0:       t += 0;
               1:       t += 59;
               2:       t += 60;
               3:       t += HOUR_SECS - 1;
               4:       t += HOUR_SECS;
               default: t += DAY_SECS - 1;
            endcase
         end
      endcase
      if (t < 0) t = 0;
      if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF;
      return s2c_pkg::SECS_W'(t);
   endfunction

   // long hold-off on the result side, counted here so the sender keeps going
   initial begin
      forever begin
         @(hold_kick);
         holding <= 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         holding <= 1'b0;
      end
   end

   // result side: check every accepted result, then pick ready for the next edge
   initial begin
      s2c_pkg::rsp_payload_type got;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            got.year    = rsp_ch.year;
            got.month   = rsp_ch.month;
            got.day     = rsp_ch.day;
            got.weekday = rsp_ch.weekday;
            got.hour    = rsp_ch.hour;
            got.minute  = rsp_ch.minute;
            got.second  = rsp_ch.second;
            sb.check_result(got);
         end
         if (reset || holding) begin
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // watchdog
   initial begin
      int cycles;
      cycles = 0;
      while (cycles < LIMIT_CYCLES) begin
         @(posedge clock);
         cycles++;
      end
      $display("timeout after %0d cycles, %0d dates outstanding", cycles,
               sb.pending_dates.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // main sequence
   initial begin
      logic [s2c_pkg::SECS_W-1:0] directed_secs[$];

      req_ch.valid         = 1'b0;
      req_ch.epoch_seconds = '0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes, time-of-day rollovers, leap days, the common year 2100
      directed_secs.push_back(32'd0);
      directed_secs.push_back(32'd59);
      directed_secs.push_back(32'd60);
      directed_secs.push_back(32'd3599);
      directed_secs.push_back(32'd3600);
      directed_secs.push_back(32'd86399);
      directed_secs.push_back(32'd86400);
      directed_secs.push_back(s2c_pkg::SECS_W'(59 * DAY_SECS));         // 2000-02-29
      directed_secs.push_back(s2c_pkg::SECS_W'(60 * DAY_SECS));         // 2000-03-01
      directed_secs.push_back(s2c_pkg::SECS_W'(366 * DAY_SECS - 1));    // last second of 2000
      directed_secs.push_back(s2c_pkg::SECS_W'(366 * DAY_SECS));        // 2001-01-01
      directed_secs.push_back(s2c_pkg::SECS_W'(year_start_secs(2004) + 59 * DAY_SECS));
      // feb 28 and mar 1 of 2100
      directed_secs.push_back(s2c_pkg::SECS_W'(year_start_secs(2100) + 58 * DAY_SECS));
      directed_secs.push_back(s2c_pkg::SECS_W'(year_start_secs(2100) + 59 * DAY_SECS));
      directed_secs.push_back(s2c_pkg::SECS_W'(year_start_secs(2101) - 1));
      directed_secs.push_back(s2c_pkg::SECS_W'(year_start_secs(2136)));
      directed_secs.push_back(32'hFFFF_FFFF);
      directed_secs.push_back(32'hFFFF_FFFE);
      directed_secs.push_back(32'h8000_0000);
      directed_secs.push_back(32'h7FFF_FFFF);
      directed_secs.push_back(32'hAAAA_AAAA);
      directed_secs.push_back(32'h5555_5555);

      foreach (directed_secs[i]) begin
         send_request(directed_secs[i]);
      end
      // sender waits here until every directed date is back
      pause_until_drained();

      // random phases: no idling, idle sender, stalling receiver, both
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 65; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 65; end
            default: begin send_idle_pct = 31; recv_stall_pct = 31; end
         endcase
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // block the result side early in the first phase so the request side backs up
            if (ph == 0 && i == 20) -> hold_kick;
            send_request(pick_seconds());
         end
         pause_until_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("converted %0d instants across directed edges and four idle mixes", requests_sent);
      $display("%0d dates checked, %0d mismatches, %0d left waiting",
               sb.checked, sb.mismatches, sb.pending_dates.size());
      if (sb.mismatches == 0 && sb.pending_dates.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
